[design/rgc_pkg.sv]
`default_nettype none

package rgc_pkg;

  // Field widths of the request and result transactions.
  localparam int PAGE_W  = 16;
  localparam int GROUP_W = 14;
  localparam int PIG_W   = 2;
  localparam int IMAGE_W = 24;
  localparam int CLOCK_W = 32;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;

  // Group geometry: pages per group, page size and banked windows in use.
  localparam int PAGES_PER_GROUP = 4;
  localparam int GROUP_SHIFT     = $clog2(PAGES_PER_GROUP);
  localparam int PAGE_SHIFT      = 13;
  localparam int OFFSET_W        = GROUP_W + GROUP_SHIFT + PAGE_SHIFT;
  localparam int INPUT_WINDOWS   = 4;
  localparam int BANK_WINDOWS    = 4;

  // The remainder is produced one dividend bit per cycle.
  localparam int DIV_STEPS = PAGE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BYTES = 1'd1;

  // Result status codes.
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_FILLED   = 2'd1;
  localparam logic [1:0] ST_NO_PAGES = 2'd2;
  localparam logic [1:0] ST_BEYOND   = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0] requested_page;
    logic [PAGE_W-1:0] banked_page_a;
    logic [PAGE_W-1:0] banked_page_b;
    logic [PAGE_W-1:0] banked_page_c;
    logic [PAGE_W-1:0] banked_page_d;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         slot;
    logic [GROUP_W-1:0] group;
    logic [PIG_W-1:0]   page_in_group;
    logic               evicted_valid;
    logic [GROUP_W-1:0] evicted_group;
    logic               aliased;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new request and clear the scan trackers
    logic div_step;  // one restoring remainder step
    logic scan;      // examine the slot under the scan index
    logic finish;    // build the result and update the slots
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pc_zero;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

[design/rgc_ctrl.sv]
`default_nettype none

module rgc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rgc_pkg::sts_t sts,
  output rgc_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [rgc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer: capture, divide, scan the slots, then commit the result; with no pages, commit follows capture.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          state_nxt = sts.pc_zero ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == rgc_pkg::DIV_CNT_W'(rgc_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[design/rgc_datapath.sv]
`default_nettype none

module rgc_datapath #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rgc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire rgc_pkg::in_t                  in_data,
  input  wire rgc_pkg::cmd_t                 cmd,
  output rgc_pkg::sts_t                      sts,
  output rgc_pkg::out_t                      out_data
);

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW     = rgc_pkg::PAGE_W;
  localparam int GW     = rgc_pkg::GROUP_W;
  localparam int CW     = rgc_pkg::CLOCK_W;
  localparam int LOW_W  = rgc_pkg::GROUP_SHIFT + rgc_pkg::PAGE_SHIFT;

  // Configuration registers.
  logic [PW-1:0]                page_count_r;
  logic [rgc_pkg::IMAGE_W-1:0]  image_bytes_r;

  // Request capture and remainder unit.
  logic [PW-1:0] req_r;
  logic [PW-1:0] dvd_r;
  logic [PW-1:0] rem_r;
  logic [GW-1:0] bank_grp_r [rgc_pkg::INPUT_WINDOWS];

  // Slot storage and the use clock.
  logic          valid_r [SLOT_COUNT];
  logic [GW-1:0] tag_r   [SLOT_COUNT];
  logic [CW-1:0] age_r   [SLOT_COUNT];
  logic [CW-1:0] use_clock_r;

  // Scan trackers.
  logic [SIDX_W-1:0] idx_r;
  logic              hit_found_r, empty_found_r, cand_found_r;
  logic [SIDX_W-1:0] hit_slot_r, empty_slot_r, cand_slot_r;
  logic [CW-1:0]     cand_age_r;

  rgc_pkg::out_t out_r, res;

  logic [PW:0]        rem_sh;
  logic [PW-1:0]      rem_step;
  logic [GW-1:0]      grp;
  logic               s_valid, s_hit, s_pinned;
  logic [GW-1:0]      s_tag;
  logic [CW-1:0]      s_age;
  logic [SIDX_W-1:0]  victim, fin_slot;
  logic [SIDX_W+1:0]  slot_wide;
  logic [CW-1:0]      clock_inc;
  logic [rgc_pkg::OFFSET_W-1:0] offset;
  logic               beyond;

  assign sts.pc_zero   = (page_count_r == '0);
  assign sts.scan_last = (idx_r == SIDX_W'(SLOT_COUNT - 1));
  assign out_data      = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r  <= '0;
      image_bytes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rgc_pkg::CFG_PAGE_COUNT:  page_count_r  <= cfg_wdata[PW-1:0];
        rgc_pkg::CFG_IMAGE_BYTES: image_bytes_r <= cfg_wdata[rgc_pkg::IMAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // One restoring remainder step per cycle, most significant dividend bit first.
  assign rem_sh   = {rem_r, dvd_r[PW-1]};
  assign rem_step = (rem_sh >= {1'b0, page_count_r}) ?
                    PW'(rem_sh - {1'b0, page_count_r}) : rem_sh[PW-1:0];
  assign grp      = rem_r[PW-1:rgc_pkg::GROUP_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data.requested_page;
      dvd_r <= in_data.requested_page;
      rem_r <= '0;
      bank_grp_r[0] <= in_data.banked_page_a[PW-1:rgc_pkg::GROUP_SHIFT];
      bank_grp_r[1] <= in_data.banked_page_b[PW-1:rgc_pkg::GROUP_SHIFT];
      bank_grp_r[2] <= in_data.banked_page_c[PW-1:rgc_pkg::GROUP_SHIFT];
      bank_grp_r[3] <= in_data.banked_page_d[PW-1:rgc_pkg::GROUP_SHIFT];
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[PW-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  // Slot under the scan index: hit test and pin test against the banked groups.
  always_comb begin
    s_valid  = valid_r[idx_r];
    s_tag    = tag_r[idx_r];
    s_age    = age_r[idx_r];
    s_hit    = s_valid && (s_tag == grp);
    s_pinned = 1'b0;
    for (int w = 0; w < rgc_pkg::INPUT_WINDOWS; w++) begin
      if (w < rgc_pkg::BANK_WINDOWS && bank_grp_r[w] == s_tag) begin
        s_pinned = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r         <= '0;
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      cand_found_r  <= 1'b0;
    end else if (cmd.scan) begin
      if (!sts.scan_last) begin
        idx_r <= idx_r + 1'b1;
      end
      if (s_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_slot_r  <= idx_r;
      end
      if (!s_valid && !empty_found_r) begin
        empty_found_r <= 1'b1;
        empty_slot_r  <= idx_r;
      end
      if (s_valid && !s_pinned && (!cand_found_r || s_age < cand_age_r)) begin
        cand_found_r <= 1'b1;
        cand_slot_r  <= idx_r;
        cand_age_r   <= s_age;
      end
    end
  end

  // Result and slot update for the finished scan.
  assign victim    = empty_found_r ? empty_slot_r : (cand_found_r ? cand_slot_r : '0);
  assign fin_slot  = hit_found_r ? hit_slot_r : victim;
  assign slot_wide = {2'b00, fin_slot};
  assign clock_inc = use_clock_r + 1'b1;
  assign offset    = {grp, LOW_W'(0)};
  assign beyond    = offset >= rgc_pkg::OFFSET_W'(image_bytes_r);

  always_comb begin
    res = '0;
    if (page_count_r == '0) begin
      res.status = rgc_pkg::ST_NO_PAGES;
    end else begin
      res.slot          = slot_wide[1:0];
      res.group         = grp;
      res.page_in_group = rem_r[rgc_pkg::PIG_W-1:0];
      res.aliased       = (req_r != rem_r);
      if (hit_found_r) begin
        res.status = rgc_pkg::ST_HIT;
      end else if (beyond) begin
        res.status = rgc_pkg::ST_BEYOND;
      end else begin
        res.status        = rgc_pkg::ST_FILLED;
        res.evicted_valid = valid_r[victim];
        res.evicted_group = valid_r[victim] ? tag_r[victim] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  // A hit refreshes its age; a fill writes tag, valid and age.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_clock_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.finish && (page_count_r != '0) && (hit_found_r || !beyond)) begin
      use_clock_r       <= clock_inc;
      age_r[fin_slot]   <= clock_inc;
      valid_r[fin_slot] <= 1'b1;
      tag_r[fin_slot]   <= grp;
    end
  end

endmodule

`default_nettype wire

[design/rom_group_cache_lru_pinned_core.sv]
`default_nettype none

// Group cache lookup with least-recently-used replacement and pinning. A request
// transaction carries a program page and the four pages banked into the CPU window;
// the page is reduced modulo page_count, split into a group of four pages and
// looked up in SLOT_COUNT tagged slots, and one result transaction reports hit,
// fill (with the evicted group), no pages, or group beyond image. The block works
// on one request at a time: a bit-serial remainder unit, then a scan of tags,
// pins and ages at one slot per cycle, then a commit that waits for the result
// register to drain. While page_count is zero a request skips the divide and the
// scan. A new request can be taken while the previous result still waits.
// Configuration writes must happen only while the block is idle.
module rom_group_cache_lru_pinned_core #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rgc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rgc_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rgc_pkg::out_t                      out_data
);

  rgc_pkg::cmd_t cmd;
  rgc_pkg::sts_t sts;

  // Sequencer.
  rgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Remainder unit, slot storage and result register.
  rgc_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a request while still busy");

  // The result register is only loaded when it is free or draining.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  // A result appears only after a commit.
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without a commit");

  // Commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.scan, cmd.finish}))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

[tb/tb_rom_group_cache_lru_pinned_core.sv]
`default_nettype none

module tb_rom_group_cache_lru_pinned_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rgc_pkg::*;

  localparam int NUM_SLOTS       = 4;
  localparam int GROUP_SPAN      = PAGES_PER_GROUP * (1 << PAGE_SHIFT);
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_LIMIT    = 10;

  // Tracks the slot contents and predicts each lookup result in order.
  class slot_lookup_scoreboard;
    logic [15:0] page_count;
    logic [23:0] image_bytes;
    logic [15:0] slot_group [NUM_SLOTS];
    bit          slot_loaded [NUM_SLOTS];
    logic [31:0] slot_age [NUM_SLOTS];
    logic [31:0] use_clock;
    out_t        pending_lookups [$];
    int          mismatches;

    function new();
      page_count  = '0;
      image_bytes = '0;
      use_clock   = '0;
      mismatches  = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_group[i]  = 16'hffff;
        slot_loaded[i] = 1'b0;
        slot_age[i]    = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_PAGE_COUNT) begin
        page_count = value[15:0];
      end else if (idx == CFG_IMAGE_BYTES) begin
        image_bytes = value[23:0];
      end
    endfunction

    // A slot is pinned when any banked window, taken unreduced, falls in its group.
    function bit is_pinned(logic [15:0] grp, in_t req);
      logic [15:0] windows [4];
      windows[0] = req.banked_page_a;
      windows[1] = req.banked_page_b;
      windows[2] = req.banked_page_c;
      windows[3] = req.banked_page_d;
      for (int w = 0; w < BANK_WINDOWS && w < INPUT_WINDOWS; w++) begin
        if ((windows[w] / PAGES_PER_GROUP) == grp) return 1'b1;
      end
      return 1'b0;
    endfunction

    // First empty slot, else the oldest unpinned one, else slot zero.
    function int choose_victim(in_t req);
      int          victim;
      logic [31:0] oldest;
      bit          found;
      victim = 0;
      oldest = '0;
      found  = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_loaded[i]) return i;
        if (!is_pinned(slot_group[i], req) && (!found || slot_age[i] < oldest)) begin
          oldest = slot_age[i];
          victim = i;
          found  = 1'b1;
        end
      end
      return victim;
    endfunction

    // Works out the result of an accepted request transaction and updates the slots.
    function void note_request(in_t req);
      out_t        exp;
      int unsigned page;
      int unsigned grp;
      int          hit_slot;
      int          victim;
      longint      offset;
      exp = '0;
      if (page_count == 0) begin
        exp.status = ST_NO_PAGES;
      end else begin
        page = int'(req.requested_page) % int'(page_count);
        grp  = page / PAGES_PER_GROUP;
        exp.group         = grp[GROUP_W-1:0];
        exp.page_in_group = PIG_W'(page % PAGES_PER_GROUP);
        exp.aliased       = (int'(req.requested_page) != page);
        exp.status        = ST_HIT;
        hit_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (hit_slot < 0 && slot_loaded[i] && slot_group[i] == grp) hit_slot = i;
        end
        if (hit_slot >= 0) begin
          use_clock          = use_clock + 1;
          slot_age[hit_slot] = use_clock;
          exp.slot           = 2'(hit_slot);
        end else begin
          victim   = choose_victim(req);
          exp.slot = 2'(victim);
          offset   = longint'(grp) * GROUP_SPAN;
          if (offset >= longint'(image_bytes)) begin
            exp.status = ST_BEYOND;
          end else begin
            exp.status = ST_FILLED;
            if (slot_loaded[victim]) begin
              exp.evicted_valid = 1'b1;
              exp.evicted_group = slot_group[victim][GROUP_W-1:0];
            end
            slot_group[victim]  = grp[15:0];
            slot_loaded[victim] = 1'b1;
            use_clock           = use_clock + 1;
            slot_age[victim]    = use_clock;
          end
        end
      end
      pending_lookups.push_back(exp);
    endfunction

    function string show(out_t r);
      return $sformatf("status=%0d slot=%0d group=%0d pig=%0d evicted=%0d/%0d aliased=%0d",
                       r.status, r.slot, r.group, r.page_in_group, r.evicted_valid,
                       r.evicted_group, r.aliased);
    endfunction

    // Compares a result transaction with the oldest outstanding lookup.
    function void check_result(out_t got);
      out_t exp;
      bit   bad;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Result with no request outstanding: got %s", show(got));
        return;
      end
      exp = pending_lookups.pop_front();
      bad = (got.status !== exp.status) || (got.slot !== exp.slot) ||
            (got.group !== exp.group) || (got.page_in_group !== exp.page_in_group) ||
            (got.evicted_valid !== exp.evicted_valid) ||
            (got.evicted_group !== exp.evicted_group) || (got.aliased !== exp.aliased);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Lookup mismatch at %0t: expected %s, got %s", $realtime, show(exp),
                   show(got));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;

  slot_lookup_scoreboard board;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    hold_off_left;

  rom_group_cache_lru_pinned_core #(
    .SLOT_COUNT(NUM_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side ready: long hold-offs on request, otherwise random stalls.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every accepted result transaction is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  function automatic in_t make_request(logic [15:0] page, logic [15:0] a, logic [15:0] b,
                                       logic [15:0] c, logic [15:0] d);
    in_t req;
    req.requested_page = page;
    req.banked_page_a  = a;
    req.banked_page_b  = b;
    req.banked_page_c  = c;
    req.banked_page_d  = d;
    return req;
  endfunction

  // Banked windows sit inside the working set half of the time so that pinning matters.
  function automatic logic [15:0] random_window(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'($urandom_range(span - 1));
    if (pick < 80) return 16'($urandom_range(16'hffff));
    return 16'hffff - 16'($urandom_range(3));
  endfunction

  // Requests favor a working set of up to six groups, some aliased above page_count.
  function automatic in_t random_request(int unsigned pc);
    int unsigned span;
    int unsigned pick;
    int unsigned page;
    span = (pc == 0 || pc > 24) ? 24 : pc;
    pick = $urandom_range(99);
    if (pick < 60) begin
      page = $urandom_range(span - 1);
      if (pc != 0 && $urandom_range(99) < 30)
        page += pc * $urandom_range((16'hffff - page) / pc);
    end else if (pick < 85) begin
      page = $urandom_range(16'hffff);
    end else begin
      page = 16'hffff - $urandom_range(8);
    end
    return make_request(page[15:0], random_window(span), random_window(span),
                        random_window(span), random_window(span));
  endfunction

  // Offers one request transaction; called and returns at a falling edge, valid still high.
  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    board.set_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_lookups.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One configuration with its own idling mix and a run of random requests.
  task automatic run_phase(int unsigned pc, int unsigned img, int items, int send_idle,
                           int recv_stall, bit hold_off);
    wait_drained();
    write_register(CFG_PAGE_COUNT, CFG_W'(pc));
    write_register(CFG_IMAGE_BYTES, CFG_W'(img));
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    if (hold_off) hold_off_left = HOLD_OFF_CYCLES;
    repeat (items) send_request(random_request(pc));
  endtask

  // Main sequence: reset, directed corners, then random phases.
  initial begin
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PAGE_COUNT;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No pages with the reset configuration.
    send_request(make_request(16'h1234, 16'h0000, 16'hffff, 16'haaaa, 16'h5555));
    send_request(make_request(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));

    // Largest page count and image: fills, an aliased hit, a group beyond the image.
    wait_drained();
    write_register(CFG_PAGE_COUNT, CFG_W'(16'hffff));
    write_register(CFG_IMAGE_BYTES, 24'hffffff);
    send_request(make_request(16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'hfffe, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd4, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd8, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd12, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    // Eviction around one pinned group, then with every slot pinned.
    send_request(make_request(16'd16, 16'd0, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd21, 16'd0, 16'd17, 16'd9, 16'd14));
    send_request(make_request(16'd3, 16'hfff0, 16'h5555, 16'haaaa, 16'h0100));
    send_request(make_request(16'd22, 16'd20, 16'd0, 16'd16, 16'd8));

    // A single page: every request lands on page zero.
    wait_drained();
    write_register(CFG_PAGE_COUNT, CFG_W'(1));
    send_request(make_request(16'h0000, 16'haaaa, 16'h5555, 16'h0000, 16'hffff));
    send_request(make_request(16'hffff, 16'h5555, 16'haaaa, 16'hffff, 16'h0000));

    // Empty image: only groups already held can hit.
    wait_drained();
    write_register(CFG_PAGE_COUNT, CFG_W'(16'hffff));
    write_register(CFG_IMAGE_BYTES, 24'h000000);
    send_request(make_request(16'h4000, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd20, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));

    // Image of exactly one group: group one starts at the boundary.
    wait_drained();
    write_register(CFG_IMAGE_BYTES, CFG_W'(GROUP_SPAN));
    send_request(make_request(16'd5, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(16'd2, 16'hffff, 16'hffff, 16'hffff, 16'hffff));

    // Random phases over several settings and idling mixes.
    run_phase(64, 24'hffffff, 80, 0, 0, 1'b0);
    run_phase(37, 5 * GROUP_SPAN + 1, 80, 49, 0, 1'b0);
    run_phase(16'hffff, 24'hffffff, 90, 0, 49, 1'b1);
    run_phase(4000, 24'h100000, 60, 19, 19, 1'b0);
    run_phase(0, 24'hffffff, 15, 19, 19, 1'b0);
    run_phase(1, 0, 40, 0, 0, 1'b0);
    run_phase(23, GROUP_SPAN, 80, 19, 19, 1'b0);
    run_phase($urandom_range(16'hffff, 1), $urandom_range(24'hffffff), 60, 19, 19, 1'b0);

    // Let the last results drain, then give the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.mismatches == 0 && board.pending_lookups.size() == 0) begin
      $display("rom_group_cache_lru_pinned_core test passed");
    end else begin
      $display("rom_group_cache_lru_pinned_core test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("rom_group_cache_lru_pinned_core test failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/rgc_pkg.sv
design/rgc_ctrl.sv
design/rgc_datapath.sv
design/rom_group_cache_lru_pinned_core.sv
tb/tb_rom_group_cache_lru_pinned_core.sv
